// ===== rtl/circ_pkg.sv =====
// Shared widths, types and pipeline words for the circumcircle core.
`default_nettype none
package circ_pkg;

    // coordinate width and derived widths
    localparam int CW   = 24;            // coordinate width
    localparam int RW   = CW - 1;        // radius width
    localparam int HB   = CW + 1;        // width of a point difference, split point of |u|^2
    localparam int UW   = 2 * CW + 2;    // |u|^2, |v|^2 (unsigned)
    localparam int DW   = 2 * CW + 3;    // determinant D, partial products (signed)
    localparam int NW   = 2 * CW + HB + 3; // center numerators (signed)
    localparam int NPW  = NW + 2;        // rounded dividend 2|n| + 2|D|
    localparam int DVW  = DW + 2;        // divisor 4|D|
    localparam int QB   = CW + 3;        // quotient bits kept
    localparam int RDW  = DVW + QB;      // divider remainder
    localparam int DSW  = DVW + QB - 1;  // aligned divisor
    localparam int SQW  = 2 * RW + 2;    // root operand
    localparam int SQN  = RW + 1;        // root steps

    // point coordinates carried along the front and divider
    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x3;
        logic signed [CW-1:0] y3;
    } t_pts;

    // side data beside the divider lanes
    typedef struct packed {
        t_pts pts;
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
        logic degen;
    } t_div_side;

    // one divider stage word, two lanes
    typedef struct packed {
        logic [RDW-1:0] rem_x;
        logic [RDW-1:0] rem_y;
        logic [QB-1:0]  q_x;
        logic [QB-1:0]  q_y;
        logic [DSW-1:0] dsh;
        t_div_side      side;
    } t_div_word;

    // side data beside the root chain
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic ovf;
        logic rbig;
        logic degen;
    } t_sqrt_side;

    // one root stage word
    typedef struct packed {
        logic [SQW-1:0] op;
        logic [SQW-1:0] res;
        logic [SQW-1:0] one;
        t_sqrt_side     side;
    } t_sqrt_word;

endpackage
`default_nettype wire

// ===== rtl/circ_front.sv =====
// Front pipeline: differences, exact products, numerators and divider setup.
`default_nettype none
module circ_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [circ_pkg::CW-1:0]  i_x1,
    input  logic signed [circ_pkg::CW-1:0]  i_y1,
    input  logic signed [circ_pkg::CW-1:0]  i_x2,
    input  logic signed [circ_pkg::CW-1:0]  i_y2,
    input  logic signed [circ_pkg::CW-1:0]  i_x3,
    input  logic signed [circ_pkg::CW-1:0]  i_y3,
    output logic                            o_valid,
    output circ_pkg::t_div_word             o_word
);

    logic [6:0] r_v;

    circ_pkg::t_pts r1_p, r2_p, r3_p, r4_p, r5_p, r6_p;

    // stage 1: u = P2 - P1, v = P3 - P1
    logic signed [circ_pkg::CW:0] r1_ux, r1_uy, r1_vx, r1_vy;
    // stage 2: products
    logic signed [circ_pkg::CW:0] r2_ux, r2_uy, r2_vx, r2_vy;
    logic signed [2*circ_pkg::CW+1:0] r2_pa, r2_pb, r2_sxx, r2_syy, r2_svx, r2_svy;
    // stage 3: D, |u|^2, |v|^2
    logic signed [circ_pkg::CW:0] r3_ux, r3_uy, r3_vx, r3_vy;
    logic signed [circ_pkg::DW-1:0] r3_d;
    logic [circ_pkg::UW-1:0] r3_uu, r3_vv;
    // stage 4: partial products of the numerators
    logic signed [circ_pkg::DW-1:0] r4_d;
    logic signed [circ_pkg::DW-1:0] r4_uhvy, r4_ulvy, r4_vhuy, r4_vluy;
    logic signed [circ_pkg::DW-1:0] r4_vhux, r4_vlux, r4_uhvx, r4_ulvx;
    // stage 5: numerators
    logic signed [circ_pkg::DW-1:0] r5_d;
    logic signed [circ_pkg::NW-1:0] r5_nx, r5_ny;
    logic r5_degen;
    // stage 6: magnitudes and signs
    logic [circ_pkg::NW-1:0] r6_anx, r6_any;
    logic [circ_pkg::DW-1:0] r6_ad;
    logic r6_neg_x, r6_neg_y, r6_degen;
    // stage 7: divider word
    circ_pkg::t_div_word r7_w;

    logic signed [circ_pkg::DW:0]   w_hx, w_lx, w_hy, w_ly;
    logic signed [circ_pkg::NW-1:0] w_nx, w_ny;
    logic [circ_pkg::NPW-1:0]       w_npx, w_npy;
    logic [circ_pkg::DVW-1:0]       w_dvs;

    // numerator assembly from the split products
    always_comb begin
        w_hx = $signed({r4_uhvy[circ_pkg::DW-1], r4_uhvy})
             - $signed({r4_vhuy[circ_pkg::DW-1], r4_vhuy});
        w_lx = $signed({r4_ulvy[circ_pkg::DW-1], r4_ulvy})
             - $signed({r4_vluy[circ_pkg::DW-1], r4_vluy});
        w_hy = $signed({r4_vhux[circ_pkg::DW-1], r4_vhux})
             - $signed({r4_uhvx[circ_pkg::DW-1], r4_uhvx});
        w_ly = $signed({r4_vlux[circ_pkg::DW-1], r4_vlux})
             - $signed({r4_ulvx[circ_pkg::DW-1], r4_ulvx});
        w_nx = $signed({w_hx[circ_pkg::NW-circ_pkg::HB-1:0], {circ_pkg::HB{1'b0}}})
             + $signed({{(circ_pkg::NW-circ_pkg::DW-1){w_lx[circ_pkg::DW]}}, w_lx});
        w_ny = $signed({w_hy[circ_pkg::NW-circ_pkg::HB-1:0], {circ_pkg::HB{1'b0}}})
             + $signed({{(circ_pkg::NW-circ_pkg::DW-1){w_ly[circ_pkg::DW]}}, w_ly});
    end

    // rounded dividend 2|n| + 2|D| and divisor 4|D|
    always_comb begin
        w_npx = {1'b0, r6_anx, 1'b0} + {{(circ_pkg::NPW-circ_pkg::DW-1){1'b0}}, r6_ad, 1'b0};
        w_npy = {1'b0, r6_any, 1'b0} + {{(circ_pkg::NPW-circ_pkg::DW-1){1'b0}}, r6_ad, 1'b0};
        w_dvs = {r6_ad, 2'b00};
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p  <= '{x1: i_x1, y1: i_y1, x3: i_x3, y3: i_y3};
            r1_ux <= $signed({i_x2[circ_pkg::CW-1], i_x2}) - $signed({i_x1[circ_pkg::CW-1], i_x1});
            r1_uy <= $signed({i_y2[circ_pkg::CW-1], i_y2}) - $signed({i_y1[circ_pkg::CW-1], i_y1});
            r1_vx <= $signed({i_x3[circ_pkg::CW-1], i_x3}) - $signed({i_x1[circ_pkg::CW-1], i_x1});
            r1_vy <= $signed({i_y3[circ_pkg::CW-1], i_y3}) - $signed({i_y1[circ_pkg::CW-1], i_y1});

            r2_p   <= r1_p;
            r2_ux  <= r1_ux;
            r2_uy  <= r1_uy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_pa  <= r1_ux * r1_vy;
            r2_pb  <= r1_uy * r1_vx;
            r2_sxx <= r1_ux * r1_ux;
            r2_syy <= r1_uy * r1_uy;
            r2_svx <= r1_vx * r1_vx;
            r2_svy <= r1_vy * r1_vy;

            r3_p  <= r2_p;
            r3_ux <= r2_ux;
            r3_uy <= r2_uy;
            r3_vx <= r2_vx;
            r3_vy <= r2_vy;
            r3_d  <= $signed({r2_pa[2*circ_pkg::CW+1], r2_pa})
                   - $signed({r2_pb[2*circ_pkg::CW+1], r2_pb});
            r3_uu <= $unsigned(r2_sxx + r2_syy);
            r3_vv <= $unsigned(r2_svx + r2_svy);

            r4_p    <= r3_p;
            r4_d    <= r3_d;
            r4_uhvy <= $signed({1'b0, r3_uu[circ_pkg::UW-1:circ_pkg::HB]}) * r3_vy;
            r4_ulvy <= $signed({1'b0, r3_uu[circ_pkg::HB-1:0]}) * r3_vy;
            r4_vhuy <= $signed({1'b0, r3_vv[circ_pkg::UW-1:circ_pkg::HB]}) * r3_uy;
            r4_vluy <= $signed({1'b0, r3_vv[circ_pkg::HB-1:0]}) * r3_uy;
            r4_vhux <= $signed({1'b0, r3_vv[circ_pkg::UW-1:circ_pkg::HB]}) * r3_ux;
            r4_vlux <= $signed({1'b0, r3_vv[circ_pkg::HB-1:0]}) * r3_ux;
            r4_uhvx <= $signed({1'b0, r3_uu[circ_pkg::UW-1:circ_pkg::HB]}) * r3_vx;
            r4_ulvx <= $signed({1'b0, r3_uu[circ_pkg::HB-1:0]}) * r3_vx;

            r5_p     <= r4_p;
            r5_d     <= r4_d;
            r5_nx    <= w_nx;
            r5_ny    <= w_ny;
            r5_degen <= (r4_d == '0);

            r6_p     <= r5_p;
            r6_anx   <= r5_nx[circ_pkg::NW-1] ? $unsigned(-r5_nx) : $unsigned(r5_nx);
            r6_any   <= r5_ny[circ_pkg::NW-1] ? $unsigned(-r5_ny) : $unsigned(r5_ny);
            r6_ad    <= r5_d[circ_pkg::DW-1] ? $unsigned(-r5_d) : $unsigned(r5_d);
            r6_neg_x <= r5_nx[circ_pkg::NW-1] ^ r5_d[circ_pkg::DW-1];
            r6_neg_y <= r5_ny[circ_pkg::NW-1] ^ r5_d[circ_pkg::DW-1];
            r6_degen <= r5_degen;

            r7_w.rem_x <= {{(circ_pkg::RDW-circ_pkg::NPW){1'b0}}, w_npx};
            r7_w.rem_y <= {{(circ_pkg::RDW-circ_pkg::NPW){1'b0}}, w_npy};
            r7_w.q_x   <= '0;
            r7_w.q_y   <= '0;
            r7_w.dsh   <= {w_dvs, {(circ_pkg::QB-1){1'b0}}};
            r7_w.side.pts   <= r6_p;
            r7_w.side.neg_x <= r6_neg_x;
            r7_w.side.neg_y <= r6_neg_y;
            // quotient would not fit the kept bits: center is far out of range
            r7_w.side.big_x <= ({{(circ_pkg::RDW-circ_pkg::NPW){1'b0}}, w_npx}
                                >= {w_dvs, {circ_pkg::QB{1'b0}}});
            r7_w.side.big_y <= ({{(circ_pkg::RDW-circ_pkg::NPW){1'b0}}, w_npy}
                                >= {w_dvs, {circ_pkg::QB{1'b0}}});
            r7_w.side.degen <= r6_degen;
        end
    end

    assign o_valid = r_v[6];
    assign o_word  = r7_w;

endmodule
`default_nettype wire

// ===== rtl/circ_div_cell.sv =====
// One restoring-division cell: one quotient bit for each of two lanes.
`default_nettype none
module circ_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  circ_pkg::t_div_word i_word,
    output logic                o_valid,
    output circ_pkg::t_div_word o_word
);

    logic                r_valid;
    circ_pkg::t_div_word r_word;
    circ_pkg::t_div_word n_word;
    logic [circ_pkg::RDW-1:0] w_dsh;
    logic [circ_pkg::RDW-1:0] w_rx, w_ry;
    logic w_gx, w_gy;

    // compare, subtract, shift
    always_comb begin
        w_dsh  = {1'b0, i_word.dsh};
        w_gx   = (i_word.rem_x >= w_dsh);
        w_gy   = (i_word.rem_y >= w_dsh);
        w_rx   = w_gx ? (i_word.rem_x - w_dsh) : i_word.rem_x;
        w_ry   = w_gy ? (i_word.rem_y - w_dsh) : i_word.rem_y;
        n_word = i_word;
        n_word.rem_x = {w_rx[circ_pkg::RDW-2:0], 1'b0};
        n_word.rem_y = {w_ry[circ_pkg::RDW-2:0], 1'b0};
        n_word.q_x   = {i_word.q_x[circ_pkg::QB-2:0], w_gx};
        n_word.q_y   = {i_word.q_y[circ_pkg::QB-2:0], w_gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== rtl/circ_sqrt_cell.sv =====
// One integer square-root cell: settles one result bit.
`default_nettype none
module circ_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  circ_pkg::t_sqrt_word i_word,
    output logic                 o_valid,
    output circ_pkg::t_sqrt_word o_word
);

    logic                 r_valid;
    circ_pkg::t_sqrt_word r_word;
    circ_pkg::t_sqrt_word n_word;
    logic [circ_pkg::SQW-1:0] w_trial;
    logic w_ge;

    // trial subtract of res + one
    always_comb begin
        w_trial = i_word.res + i_word.one;
        w_ge    = (i_word.op >= w_trial);
        n_word  = i_word;
        n_word.op  = w_ge ? (i_word.op - w_trial) : i_word.op;
        n_word.res = w_ge ? ((i_word.res >> 1) + i_word.one) : (i_word.res >> 1);
        n_word.one = i_word.one >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== rtl/circumcircle_three_points_core.sv =====
// Circumcircle of three points: top level with divider and root cell chains.
//
// Input channel: i_valid with the six point coordinates (signed Q12.12);
// the block drives o_stall. A request is taken on a rising edge with
// i_valid high and o_stall low. Output channel: o_valid with center,
// radius, degenerate and overflow; the receiver drives i_stall.
// Throughput: one request per clock when o_stall is low. Acceptance
// to o_valid: 7 front stages, 27 divider cells giving one quotient bit
// each, 5 post stages, 24 square-root cells, 1 output register.
// Collinear or coincident points give degenerate = 1 with all other
// fields zero. Synchronous active-low reset empties the pipeline.
// While the output register holds a result and i_stall is high, the
// whole pipeline holds and o_stall is high; with an empty output
// register the pipeline keeps moving regardless of i_stall.
`default_nettype none
module circumcircle_three_points_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [circ_pkg::CW-1:0]  i_first_x,
    input  logic signed [circ_pkg::CW-1:0]  i_first_y,
    input  logic signed [circ_pkg::CW-1:0]  i_second_x,
    input  logic signed [circ_pkg::CW-1:0]  i_second_y,
    input  logic signed [circ_pkg::CW-1:0]  i_third_x,
    input  logic signed [circ_pkg::CW-1:0]  i_third_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [circ_pkg::CW-1:0]  o_center_x,
    output logic signed [circ_pkg::CW-1:0]  o_center_y,
    output logic [circ_pkg::RW-1:0]         o_radius,
    output logic                            o_degenerate,
    output logic                            o_overflow
);

    logic w_en;

    circ_pkg::t_div_word  w_dw [0:circ_pkg::QB];
    logic [circ_pkg::QB:0] w_dv;
    circ_pkg::t_sqrt_word w_sw [0:circ_pkg::SQN];
    logic [circ_pkg::SQN:0] w_sv;

    logic [4:0] r_pv;

    // post stage 1: signed quotients
    logic signed [circ_pkg::QB:0] r1_qx, r1_qy;
    circ_pkg::t_div_side r1_s;
    // post stage 2: centers
    logic signed [circ_pkg::QB+1:0] r2_cx, r2_cy;
    circ_pkg::t_div_side r2_s;
    // post stage 3: distances and clamped centers
    logic [circ_pkg::QB+2:0] r3_adx, r3_ady;
    circ_pkg::t_sqrt_side r3_s;
    // post stage 4: squares
    logic [2*circ_pkg::RW-1:0] r4_sqx, r4_sqy;
    circ_pkg::t_sqrt_side r4_s;
    // post stage 5: root chain entry
    circ_pkg::t_sqrt_word r5_w;

    // output register
    logic r_out_valid;
    logic signed [circ_pkg::CW-1:0] r_cx, r_cy;
    logic [circ_pkg::RW-1:0] r_rad;
    logic r_degen, r_ovf;

    logic [circ_pkg::QB-1:0]   w_qmx, w_qmy;
    logic signed [circ_pkg::QB+2:0] w_dx, w_dy;
    logic w_cx_out, w_cy_out;
    logic signed [circ_pkg::CW-1:0] w_cx_sat, w_cy_sat;
    circ_pkg::t_sqrt_side w_s4;
    logic [circ_pkg::RW+1:0] w_rad;
    logic w_rsat;

    localparam logic signed [circ_pkg::CW-1:0] C_MAX = {1'b0, {(circ_pkg::CW-1){1'b1}}};
    localparam logic signed [circ_pkg::CW-1:0] C_MIN = {1'b1, {(circ_pkg::CW-1){1'b0}}};

    // pipeline moves unless a held result is stalled
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    circ_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x1    (i_first_x),
        .i_y1    (i_first_y),
        .i_x2    (i_second_x),
        .i_y2    (i_second_y),
        .i_x3    (i_third_x),
        .i_y3    (i_third_y),
        .o_valid (w_dv[0]),
        .o_word  (w_dw[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < circ_pkg::QB; g++) begin : g_div
        circ_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_word  (w_dw[g]),
            .o_valid (w_dv[g+1]),
            .o_word  (w_dw[g+1])
        );
    end

    // post-divider combinational pieces
    always_comb begin
        w_qmx    = w_dw[circ_pkg::QB].side.big_x ? '1 : w_dw[circ_pkg::QB].q_x;
        w_qmy    = w_dw[circ_pkg::QB].side.big_y ? '1 : w_dw[circ_pkg::QB].q_y;
        w_dx     = $signed({r2_cx[circ_pkg::QB+1], r2_cx})
                 - $signed({{(circ_pkg::QB+3-circ_pkg::CW){r2_s.pts.x3[circ_pkg::CW-1]}},
                            r2_s.pts.x3});
        w_dy     = $signed({r2_cy[circ_pkg::QB+1], r2_cy})
                 - $signed({{(circ_pkg::QB+3-circ_pkg::CW){r2_s.pts.y3[circ_pkg::CW-1]}},
                            r2_s.pts.y3});
        w_cx_out = !((&r2_cx[circ_pkg::QB+1:circ_pkg::CW-1]) ||
                     !(|r2_cx[circ_pkg::QB+1:circ_pkg::CW-1]));
        w_cy_out = !((&r2_cy[circ_pkg::QB+1:circ_pkg::CW-1]) ||
                     !(|r2_cy[circ_pkg::QB+1:circ_pkg::CW-1]));
        w_cx_sat = w_cx_out ? (r2_cx[circ_pkg::QB+1] ? C_MIN : C_MAX)
                            : r2_cx[circ_pkg::CW-1:0];
        w_cy_sat = w_cy_out ? (r2_cy[circ_pkg::QB+1] ? C_MIN : C_MAX)
                            : r2_cy[circ_pkg::CW-1:0];
        // distance beyond the radius range
        w_s4      = r3_s;
        w_s4.rbig = (|r3_adx[circ_pkg::QB+2:circ_pkg::RW])
                 || (|r3_ady[circ_pkg::QB+2:circ_pkg::RW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[3:0], w_dv[circ_pkg::QB]};
        end
    end

    // post stages 1 to 5
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s  <= w_dw[circ_pkg::QB].side;
            r1_qx <= w_dw[circ_pkg::QB].side.neg_x ? -$signed({1'b0, w_qmx})
                                                   : $signed({1'b0, w_qmx});
            r1_qy <= w_dw[circ_pkg::QB].side.neg_y ? -$signed({1'b0, w_qmy})
                                                   : $signed({1'b0, w_qmy});

            r2_s  <= r1_s;
            r2_cx <= $signed({{(circ_pkg::QB+2-circ_pkg::CW){r1_s.pts.x1[circ_pkg::CW-1]}},
                              r1_s.pts.x1}) + $signed({r1_qx[circ_pkg::QB], r1_qx});
            r2_cy <= $signed({{(circ_pkg::QB+2-circ_pkg::CW){r1_s.pts.y1[circ_pkg::CW-1]}},
                              r1_s.pts.y1}) + $signed({r1_qy[circ_pkg::QB], r1_qy});

            r3_adx     <= w_dx[circ_pkg::QB+2] ? $unsigned(-w_dx) : $unsigned(w_dx);
            r3_ady     <= w_dy[circ_pkg::QB+2] ? $unsigned(-w_dy) : $unsigned(w_dy);
            r3_s.cx    <= w_cx_sat;
            r3_s.cy    <= w_cy_sat;
            r3_s.ovf   <= w_cx_out || w_cy_out;
            r3_s.rbig  <= 1'b0;
            r3_s.degen <= r2_s.degen;

            r4_s      <= w_s4;
            r4_sqx    <= r3_adx[circ_pkg::RW-1:0] * r3_adx[circ_pkg::RW-1:0];
            r4_sqy    <= r3_ady[circ_pkg::RW-1:0] * r3_ady[circ_pkg::RW-1:0];

            r5_w.op   <= {2'b00, r4_sqx} + {2'b00, r4_sqy};
            r5_w.res  <= '0;
            r5_w.one  <= {2'b01, {(2*circ_pkg::RW){1'b0}}};
            r5_w.side <= r4_s;
        end
    end

    assign w_sv[0] = r_pv[4];
    assign w_sw[0] = r5_w;

    // root chain, one result bit per cell
    for (genvar g = 0; g < circ_pkg::SQN; g++) begin : g_sqrt
        circ_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_word  (w_sw[g]),
            .o_valid (w_sv[g+1]),
            .o_word  (w_sw[g+1])
        );
    end

    // round the root, halves up, then saturate
    always_comb begin
        w_rad  = {1'b0, w_sw[circ_pkg::SQN].res[circ_pkg::RW:0]}
               + {{(circ_pkg::RW+1){1'b0}},
                  (w_sw[circ_pkg::SQN].op > w_sw[circ_pkg::SQN].res)};
        w_rsat = w_sw[circ_pkg::SQN].side.rbig || (|w_rad[circ_pkg::RW+1:circ_pkg::RW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sv[circ_pkg::SQN];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sw[circ_pkg::SQN].side.degen) begin
                r_cx    <= '0;
                r_cy    <= '0;
                r_rad   <= '0;
                r_degen <= 1'b1;
                r_ovf   <= 1'b0;
            end else begin
                r_cx    <= w_sw[circ_pkg::SQN].side.cx;
                r_cy    <= w_sw[circ_pkg::SQN].side.cy;
                r_rad   <= w_rsat ? '1 : w_rad[circ_pkg::RW-1:0];
                r_degen <= 1'b0;
                r_ovf   <= w_sw[circ_pkg::SQN].side.ovf || w_rsat;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_center_x   = r_cx;
    assign o_center_y   = r_cy;
    assign o_radius     = r_rad;
    assign o_degenerate = r_degen;
    assign o_overflow   = r_ovf;

    // a degenerate result carries nothing else
    a_degen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_center_x == '0 && o_center_y == '0 && o_radius == '0 && !o_overflow))
        else $error("degenerate result with nonzero fields");

    // input side only stalls behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without an output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
